// ----- hw/rtl/bpa_pkg.sv -----
// Shared constants, types and helpers of the buddy page allocator.
`default_nettype none

package bpa_pkg;

    localparam int TOP_ORDER_DEF = 10;
    localparam int TOP_COUNT_DEF = 16;
    localparam int PAGE_BITS_DEF = 12;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 22;
    localparam int TOPB_W   = 5;
    localparam int WORD_W   = 32;
    localparam int WSEL_W   = 5;
    localparam int PADDR_W  = 3;
    localparam int IN_DATA_W = 56;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        REG_BASE = 1'b0,
        REG_TOPB = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        status_t           status;
    } result_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_START,
        S_A_RD,
        S_A_CHK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_REC,
        S_F_START,
        S_F_RD,
        S_F_CHK,
        S_B_RD,
        S_B_CHK,
        S_SET_RD,
        S_SET_WR,
        S_DONE
    } state_t;

    // Index of the lowest set bit of a free-mark word.
    function automatic logic [WSEL_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [WSEL_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i])
            begin
                r = WSEL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bpa_ram.sv -----
// Single-port RAM with registered read data.
`default_nettype none

module bpa_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bpa_ctrl.sv -----
// Sequencer, free-mark map and order table of the buddy page allocator.
`default_nettype none

module bpa_ctrl #(
    parameter int TOP_ORDER = bpa_pkg::TOP_ORDER_DEF,
    parameter int TOP_COUNT = bpa_pkg::TOP_COUNT_DEF,
    parameter int PAGE_BITS = bpa_pkg::PAGE_BITS_DEF,
    parameter int UT_W      = $clog2(TOP_COUNT + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clear_start,
    input  wire logic [UT_W-1:0]            usable,
    input  wire logic [bpa_pkg::ADDR_W-1:0] base_addr,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire bpa_pkg::kind_t             in_kind,
    input  wire logic [bpa_pkg::SIZE_W-1:0] in_size,
    input  wire logic [bpa_pkg::ADDR_W-1:0] in_addr,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output bpa_pkg::result_t                res
);

    import bpa_pkg::*;

    localparam int ORDERS    = TOP_ORDER + 1;
    localparam int PAGES     = TOP_COUNT << TOP_ORDER;
    localparam int PN_W      = $clog2(PAGES);
    localparam int K_W       = $clog2(ORDERS);
    localparam int WPO       = (PAGES + WORD_W - 1) / WORD_W;
    localparam int WI_W      = (WPO > 1) ? $clog2(WPO) : 1;
    localparam int BX_W      = WI_W + WSEL_W;
    localparam int FA_W      = K_W + WI_W;
    localparam int FM_DEPTH  = ORDERS << WI_W;
    localparam int CLR_DEPTH = (FM_DEPTH > PAGES) ? FM_DEPTH : PAGES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int PG_W      = SIZE_W + 1;
    localparam int OD_W      = K_W + 1;
    localparam logic [63:0] SIZE_LIM = 64'd1 << (TOP_ORDER + PAGE_BITS);

    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]    faddr_reg, faddr_next;
    logic [K_W-1:0]       want_reg, want_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [WI_W-1:0]      widx_reg, widx_next;
    logic [PN_W-1:0]      pn_reg, pn_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    result_t              res_reg, res_next;

    logic                 fm_we;
    logic [FA_W-1:0]      fm_addr;
    logic [WORD_W-1:0]    fm_wdata, fm_rdata;
    logic                 om_we;
    logic [PN_W-1:0]      om_addr;
    logic [OD_W-1:0]      om_wdata, om_rdata;

    logic                 clear_done;
    logic                 size_bad;
    logic [PG_W-1:0]      pages, pages_m1;
    logic [K_W-1:0]       want_calc;
    logic [ADDR_W-1:0]    f_off;
    logic [ADDR_W-1:0]    f_pn;
    logic                 f_bad;
    logic [BX_W-1:0]      sh, blk;
    logic [WSEL_W-1:0]    fm_bit;
    logic [WORD_W-1:0]    bit_mask;
    logic                 found;
    logic [WSEL_W-1:0]    lo;
    logic [PN_W-1:0]      found_pn;
    logic [PN_W:0]        blocks_k;
    logic                 more_words;
    logic                 k_below_top;
    logic [K_W-1:0]       k_ord;
    logic [WI_W-1:0]      clr_widx;
    logic                 clr_is_top;
    logic [WORD_W-1:0]    clr_word;

    bpa_ram #(.DATA_W(WORD_W), .ADDR_W(FA_W), .DEPTH(FM_DEPTH)) u_free_map (
        .clk   (clk),
        .we    (fm_we),
        .addr  (fm_addr),
        .wdata (fm_wdata),
        .rdata (fm_rdata)
    );

    bpa_ram #(.DATA_W(OD_W), .ADDR_W(PN_W), .DEPTH(PAGES)) u_order_tab (
        .clk   (clk),
        .we    (om_we),
        .addr  (om_addr),
        .wdata (om_wdata),
        .rdata (om_rdata)
    );

    // Decode and arithmetic shared by the sequencer states.
    always_comb
    begin
        int wf;
        wf         = 0;
        clear_done = (clr_reg == CLR_W'(CLR_DEPTH - 1));
        size_bad   = (size_reg == '0) || (64'(size_reg) > SIZE_LIM);
        pages      = (PG_W'(size_reg) + PG_W'((1 << PAGE_BITS) - 1)) >> PAGE_BITS;
        pages_m1   = pages - PG_W'(1);
        for (int i = 0; i < PG_W; i++) begin
            if (pages_m1[i])
            begin
                wf = i + 1;
            end
        end
        want_calc  = K_W'(wf);

        f_off = faddr_reg - base_addr;
        f_pn  = f_off >> PAGE_BITS;
        f_bad = (faddr_reg < base_addr) || (|f_off[PAGE_BITS-1:0])
              || (f_pn >= (ADDR_W'(usable) << TOP_ORDER));

        sh = BX_W'(pn_reg) >> k_reg;
        if (state_reg == S_SPLIT_RD || state_reg == S_SPLIT_WR)
        begin
            blk = {sh[BX_W-1:1], 1'b1};
        end
        else if (state_reg == S_B_RD || state_reg == S_B_CHK)
        begin
            blk = {sh[BX_W-1:1], ~sh[0]};
        end
        else
        begin
            blk = sh;
        end
        fm_bit   = blk[WSEL_W-1:0];
        bit_mask = WORD_W'(1) << fm_bit;

        found    = |fm_rdata;
        lo       = lowest_bit(fm_rdata);
        found_pn = PN_W'({widx_reg, lo} << k_reg);
        blocks_k = (PN_W + 1)'(usable) << (K_W'(TOP_ORDER) - k_reg);
        more_words = ((32'(widx_reg) + 32'd1) << WSEL_W) < 32'(blocks_k);
        k_below_top = k_reg < K_W'(TOP_ORDER);
        k_ord = (om_rdata[K_W-1:0] > K_W'(TOP_ORDER)) ? K_W'(TOP_ORDER)
                                                       : om_rdata[K_W-1:0];

        clr_widx   = clr_reg[WI_W-1:0];
        clr_is_top = (clr_reg[FA_W-1:WI_W] == K_W'(TOP_ORDER));
        for (int i = 0; i < WORD_W; i++) begin
            clr_word[i] = clr_is_top
                       && (((32'(clr_widx) << WSEL_W) + 32'(i)) < 32'(usable));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clear_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_kind == KIND_FREE) ? S_F_START : S_A_START;
                end
            end
            S_A_START:  state_next = size_bad ? S_DONE : S_A_RD;
            S_A_RD:     state_next = S_A_CHK;
            S_A_CHK:
            begin
                if (found)
                begin
                    state_next = (k_reg > want_reg) ? S_SPLIT_RD : S_REC;
                end
                else if (more_words || k_below_top)
                begin
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SPLIT_RD: state_next = S_SPLIT_WR;
            S_SPLIT_WR: state_next = (k_reg > want_reg) ? S_SPLIT_RD : S_REC;
            S_REC:      state_next = S_DONE;
            S_F_START:  state_next = f_bad ? S_DONE : S_F_RD;
            S_F_RD:     state_next = S_F_CHK;
            S_F_CHK:
            begin
                if (!om_rdata[K_W])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = (k_ord < K_W'(TOP_ORDER)) ? S_B_RD : S_SET_RD;
                end
            end
            S_B_RD:     state_next = S_B_CHK;
            S_B_CHK:
            begin
                if (fm_rdata[fm_bit] && ((K_W + 1)'(k_reg) + 1'b1 < (K_W + 1)'(TOP_ORDER)))
                begin
                    state_next = S_B_RD;
                end
                else
                begin
                    state_next = S_SET_RD;
                end
            end
            S_SET_RD:   state_next = S_SET_WR;
            S_SET_WR:   state_next = S_DONE;
            S_DONE:     if (res_ready) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
        if (clear_start)
        begin
            state_next = S_CLEAR;
        end
    end

    always_comb
    begin
        size_next  = size_reg;
        faddr_next = faddr_reg;
        want_next  = want_reg;
        k_next     = k_reg;
        widx_next  = widx_reg;
        pn_next    = pn_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        fm_we      = 1'b0;
        fm_addr    = {k_reg, widx_reg};
        fm_wdata   = fm_rdata;
        om_we      = 1'b0;
        om_addr    = pn_reg;
        om_wdata   = '0;
        in_ready   = (state_reg == S_IDLE);
        res_valid  = (state_reg == S_DONE);

        unique case (state_reg)
            S_CLEAR:
            begin
                fm_addr  = clr_reg[FA_W-1:0];
                fm_wdata = clr_word;
                fm_we    = (CLR_W + 1)'(clr_reg) < (CLR_W + 1)'(FM_DEPTH);
                om_addr  = clr_reg[PN_W-1:0];
                om_we    = (CLR_W + 1)'(clr_reg) < (CLR_W + 1)'(PAGES);
                if (!clear_done)
                begin
                    clr_next = clr_reg + CLR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next  = in_size;
                    faddr_next = in_addr;
                end
            end
            S_A_START:
            begin
                want_next = want_calc;
                k_next    = want_calc;
                widx_next = '0;
                if (size_bad)
                begin
                    res_next = '{block_address: '0, status: ST_BAD_SIZE};
                end
            end
            S_A_CHK:
            begin
                // The first free mark found is taken right away in the same word.
                fm_wdata = fm_rdata & ~(WORD_W'(1) << lo);
                fm_we    = found;
                if (found)
                begin
                    pn_next = found_pn;
                    if (k_reg > want_reg)
                    begin
                        k_next = k_reg - K_W'(1);
                    end
                end
                else if (more_words)
                begin
                    widx_next = widx_reg + WI_W'(1);
                end
                else if (k_below_top)
                begin
                    k_next    = k_reg + K_W'(1);
                    widx_next = '0;
                end
                else
                begin
                    res_next = '{block_address: '0, status: ST_OOM};
                end
            end
            S_SPLIT_RD:
            begin
                fm_addr = {k_reg, blk[BX_W-1:WSEL_W]};
            end
            S_SPLIT_WR:
            begin
                fm_addr  = {k_reg, blk[BX_W-1:WSEL_W]};
                fm_wdata = fm_rdata | bit_mask;
                fm_we    = 1'b1;
                if (k_reg > want_reg)
                begin
                    k_next = k_reg - K_W'(1);
                end
            end
            S_REC:
            begin
                om_wdata = {1'b1, want_reg};
                om_we    = 1'b1;
                res_next = '{block_address: base_addr + (ADDR_W'(pn_reg) << PAGE_BITS),
                             status: ST_OK};
            end
            S_F_START:
            begin
                pn_next = PN_W'(f_pn);
                if (f_bad)
                begin
                    res_next = '{block_address: '0, status: ST_BAD_FREE};
                end
            end
            S_F_CHK:
            begin
                om_we = om_rdata[K_W];
                if (!om_rdata[K_W])
                begin
                    res_next = '{block_address: '0, status: ST_BAD_FREE};
                end
                else
                begin
                    k_next = k_ord;
                end
            end
            S_B_RD:
            begin
                fm_addr = {k_reg, blk[BX_W-1:WSEL_W]};
            end
            S_B_CHK:
            begin
                // A free buddy is absorbed and the merged block climbs one order.
                fm_addr  = {k_reg, blk[BX_W-1:WSEL_W]};
                fm_wdata = fm_rdata & ~bit_mask;
                fm_we    = fm_rdata[fm_bit];
                if (fm_rdata[fm_bit])
                begin
                    pn_next = pn_reg & ~(PN_W'(1) << k_reg);
                    k_next  = k_reg + K_W'(1);
                end
            end
            S_SET_RD:
            begin
                fm_addr = {k_reg, blk[BX_W-1:WSEL_W]};
            end
            S_SET_WR:
            begin
                fm_addr  = {k_reg, blk[BX_W-1:WSEL_W]};
                fm_wdata = fm_rdata | bit_mask;
                fm_we    = 1'b1;
                res_next = '{block_address: '0, status: ST_OK};
            end
            S_A_RD, S_F_RD, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        if (clear_start)
        begin
            clr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg  <= size_next;
        faddr_reg <= faddr_next;
        want_reg  <= want_next;
        k_reg     <= k_next;
        widx_reg  <= widx_next;
        pn_reg    <= pn_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

`ifndef SYNTH
    a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_CHK && fm_we) |-> $countones(fm_rdata ^ fm_wdata) == 1)
        else $error("allocation cleared other than one free mark");
    a_split_new: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT_WR) |-> !fm_rdata[fm_bit])
        else $error("split half was already marked free");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_RD || state_reg == S_A_CHK || state_reg == S_SPLIT_RD
         || state_reg == S_SPLIT_WR || state_reg == S_B_RD || state_reg == S_B_CHK
         || state_reg == S_SET_RD || state_reg == S_SET_WR)
        |-> k_reg <= K_W'(TOP_ORDER))
        else $error("order beyond top order");
    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT_RD) |-> k_reg >= want_reg)
        else $error("split went below requested order");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/buddy_page_allocator_core.sv -----
// Top level of the buddy page allocator: register port, stream ports, result register.
`default_nettype none

// Buddy allocator over pages of 2^PAGE_BITS bytes, top blocks of 2^TOP_ORDER pages.
// One request is worked at a time; s_tready is high only while the sequencer is idle.
// The free-mark memory is single-port: a step reads a word in one state and writes it in the next.
// An allocate scans free-mark words from the wanted order upward and then splits the
// found block one order at a time down to the wanted order; a bad size or no free block
// ends it without a write. A free reads the order table, then reads buddy marks and
// merges one order at a time while the buddy is free; a bad address or a page that holds
// no allocated block ends it with ST_BAD_FREE. The result then goes to the output register
// once that register is free. After reset and after every write of top_blocks the memories
// are cleared one word a cycle, with the usable top blocks marked free; no request is
// taken during the clear.
module buddy_page_allocator_core #(
    parameter int TOP_ORDER = bpa_pkg::TOP_ORDER_DEF,
    parameter int TOP_COUNT = bpa_pkg::TOP_COUNT_DEF,
    parameter int PAGE_BITS = bpa_pkg::PAGE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bpa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // alloc_size [21:0], free_address [53:22], zero fill [55:54]
    input  wire logic [bpa_pkg::IN_DATA_W-1:0] s_tdata,
    // kind [0]
    input  wire logic [0:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // block_address [31:0]
    output logic      [31:0]                   m_tdata,
    // status [1:0]
    output logic      [1:0]                    m_tuser
);

    import bpa_pkg::*;

    localparam int UT_W = $clog2(TOP_COUNT + 1);

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [TOPB_W-1:0] topb_reg, topb_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_res_reg, m_res_next;

    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic [UT_W-1:0]   usable;
    logic              clear_start;
    logic              res_valid, res_ready;
    result_t           res;

    always_comb
    begin
        cfg_idx     = reg_idx_t'(paddr[2]);
        cfg_wr      = psel && penable && pwrite;
        base_next   = base_reg;
        topb_next   = topb_reg;
        clear_start = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BASE: base_next = pwdata;
                REG_TOPB:
                begin
                    topb_next   = pwdata[TOPB_W-1:0];
                    clear_start = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        unique case (cfg_idx)
            REG_BASE: prdata = base_reg;
            REG_TOPB: prdata = 32'(topb_reg);
            default:  prdata = '0;
        endcase
        usable = (32'(topb_reg) > 32'(TOP_COUNT)) ? UT_W'(TOP_COUNT) : UT_W'(topb_reg);

        res_ready    = !m_valid_reg || m_tready;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            topb_reg    <= TOPB_W'(TOP_COUNT);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg    <= base_next;
            topb_reg    <= topb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    bpa_ctrl #(
        .TOP_ORDER (TOP_ORDER),
        .TOP_COUNT (TOP_COUNT),
        .PAGE_BITS (PAGE_BITS),
        .UT_W      (UT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .usable      (usable),
        .base_addr   (base_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (kind_t'(s_tuser[0])),
        .in_size     (s_tdata[SIZE_W-1:0]),
        .in_addr     (s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign pready   = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.block_address;
    assign m_tuser  = m_res_reg.status;

endmodule

`default_nettype wire

// ----- test/tb_buddy_page_allocator_core.sv -----
// Self-checking testbench of the buddy page allocator core with an internal allocation predictor.
`timescale 1ns / 100ps

class alloc_scoreboard;
    localparam int TOPO  = bpa_pkg::TOP_ORDER_DEF;
    localparam int TOPC  = bpa_pkg::TOP_COUNT_DEF;
    localparam int PGB   = bpa_pkg::PAGE_BITS_DEF;
    localparam int PAGES = TOPC << TOPO;

    bit                free_map [0:TOPO][0:PAGES-1];
    bit                held     [0:PAGES-1];
    bit [4:0]          held_order [0:PAGES-1];
    logic [31:0]       base_addr;
    logic [4:0]        top_blocks;
    bpa_pkg::result_t  pending [$];
    logic [31:0]       live_blocks [$];
    logic [31:0]       released [$];
    int                errors;

    function new();
        errors = 0;
        base_addr = '0;
        top_blocks = 5'(TOPC);
        clear_store();
    endfunction

    function int tops();
        return (top_blocks > TOPC) ? TOPC : int'(top_blocks);
    endfunction

    function void clear_store();
        for (int k = 0; k <= TOPO; k++)
            for (int b = 0; b < PAGES; b++)
                free_map[k][b] = 1'b0;
        for (int p = 0; p < PAGES; p++)
        begin
            held[p] = 1'b0;
            held_order[p] = '0;
        end
        for (int b = 0; b < tops(); b++)
            free_map[TOPO][b] = 1'b1;
        live_blocks.delete();
        released.delete();
    endfunction

    function void configure(bpa_pkg::reg_idx_t idx, logic [31:0] value);
        if (idx == bpa_pkg::REG_BASE)
        begin
            base_addr = value;
        end
        else
        begin
            top_blocks = value[4:0];
            clear_store();
        end
    endfunction

    function bpa_pkg::result_t allocate(logic [21:0] size);
        bpa_pkg::result_t r;
        int pages;
        int want;
        int pn;
        int half;
        r.block_address = '0;
        r.status = bpa_pkg::ST_OOM;
        if (size == 0 || 64'(size) > (64'd1 << (TOPO + PGB)))
        begin
            r.status = bpa_pkg::ST_BAD_SIZE;
            return r;
        end
        pages = (int'(size) + (1 << PGB) - 1) >> PGB;
        want = 0;
        while ((1 << want) < pages)
            want++;
        for (int k = want; k <= TOPO; k++)
            for (int b = 0; b < (tops() << (TOPO - k)); b++)
                if (free_map[k][b])
                begin
                    pn = b << k;
                    free_map[k][b] = 1'b0;
                    for (int j = k; j > want; j--)
                    begin
                        half = pn + (1 << (j - 1));
                        free_map[j-1][half >> (j - 1)] = 1'b1;
                    end
                    held[pn] = 1'b1;
                    held_order[pn] = 5'(want);
                    r.block_address = base_addr + (32'(pn) << PGB);
                    r.status = bpa_pkg::ST_OK;
                    live_blocks.push_back(r.block_address);
                    return r;
                end
        return r;
    endfunction

    function bpa_pkg::result_t release_block(logic [31:0] addr);
        bpa_pkg::result_t r;
        logic [31:0] off;
        int pn;
        int k;
        int buddy;
        r.block_address = '0;
        r.status = bpa_pkg::ST_BAD_FREE;
        if (addr < base_addr)
            return r;
        off = addr - base_addr;
        if (off[PGB-1:0] != 0)
            return r;
        if ((off >> PGB) >= 32'(tops() << TOPO))
            return r;
        pn = int'(off >> PGB);
        if (!held[pn])
            return r;
        held[pn] = 1'b0;
        k = (held_order[pn] > TOPO) ? TOPO : int'(held_order[pn]);
        held_order[pn] = '0;
        while (k < TOPO)
        begin
            buddy = pn ^ (1 << k);
            if (!free_map[k][buddy >> k])
                break;
            free_map[k][buddy >> k] = 1'b0;
            pn = pn & ~(1 << k);
            k++;
        end
        free_map[k][pn >> k] = 1'b1;
        r.status = bpa_pkg::ST_OK;
        foreach (live_blocks[i])
            if (live_blocks[i] == addr)
            begin
                live_blocks.delete(i);
                break;
            end
        released.push_back(addr);
        if (released.size() > 8)
            void'(released.pop_front());
        return r;
    endfunction

    function void note_request(bpa_pkg::kind_t kind, logic [21:0] size, logic [31:0] addr);
        if (kind == bpa_pkg::KIND_ALLOC)
            pending.push_back(allocate(size));
        else
            pending.push_back(release_block(addr));
    endfunction

    function void check_result(logic [31:0] addr, logic [1:0] status);
        bpa_pkg::result_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: result with none expected: address %h status %0d",
                     $time, addr, status);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (addr !== e.block_address)
        begin
            $display("%0t: block_address expected %h actual %h", $time, e.block_address, addr);
            errors++;
        end
        if (status !== e.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
        end
    endfunction
endclass

module tb_buddy_page_allocator_core;
    import bpa_pkg::*;

    localparam int IDLE_LIMIT = 80000;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [1:0]            m_tuser;

    alloc_scoreboard sb;
    int  hold_cycles;
    bit  calm;
    int  idle_count;

    buddy_page_allocator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random back-pressure, with occasional long stalls and a forced hold-off.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready = 1'b0;
            hold_cycles--;
        end
        else if (calm)
        begin
            m_tready = 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                hold_cycles = $urandom_range(15, 70);
            m_tready = ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(kind_t kind, logic [21:0] size, logic [31:0] addr);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {2'b00, addr, size};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, size, addr);
    endtask

    task automatic alloc_req(logic [21:0] size);
        send_request(KIND_ALLOC, size, $urandom());
    endtask

    task automatic free_req(logic [31:0] addr);
        send_request(KIND_FREE, 22'($urandom()), addr);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = PADDR_W'(idx) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.configure(idx, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_item();
        int r;
        logic [21:0] size;
        r = $urandom_range(0, 99);
        if (r < 50 || (r < 88 && sb.live_blocks.size() == 0))
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                size = $urandom_range(1, 32768);
            else if (r < 85)
                size = $urandom_range(1, 4194303);
            else if (r < 90)
                size = '0;
            else
                size = 22'($urandom());
            alloc_req(size);
        end
        else if (r < 88)
        begin
            free_req(sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
        end
        else
        begin
            r = $urandom_range(0, 2);
            if (r == 0 && sb.released.size() != 0)
                free_req(sb.released[$urandom_range(0, sb.released.size() - 1)]);
            else if (r == 1 && sb.live_blocks.size() != 0)
                free_req(sb.live_blocks[0] + 32'($urandom_range(1, 8191)));
            else
                free_req($urandom());
        end
    endtask

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ALLOC;
        m_tready = 1'b0;
        hold_cycles = 0;
        calm = 1'b0;
        idle_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests on a region that does not start at zero.
        write_reg(REG_BASE, 32'h1000_0000);
        alloc_req('0);
        alloc_req(22'd1);
        a = sb.base_addr;
        alloc_req(22'd4096);
        alloc_req(22'd4097);
        b = sb.live_blocks[sb.live_blocks.size() - 1];
        alloc_req(22'h3F_FFFF);
        free_req(32'h0FFF_F000);
        free_req(a + 32'd4);
        free_req(a + 32'h0400_0000);
        free_req(a + 32'h0000_5000);
        free_req(a);
        free_req(a);
        free_req(b);
        free_req(sb.live_blocks[0]);
        free_req(sb.live_blocks[0]);
        drain();

        // Exhaust a single top block, then hand it back piece by piece.
        write_reg(REG_TOPB, 32'd1);
        write_reg(REG_BASE, 32'hFFFF_F000);
        repeat (4) alloc_req(22'd1 << 20);
        alloc_req(22'd1);
        for (int i = 0; i < 4; i++)
            free_req(32'hFFFF_F000 + (32'(i) << 20));
        alloc_req(22'h3F_FFFF);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_reg(REG_TOPB, 32'd16);
                1: write_reg(REG_TOPB, 32'd0);
                2: write_reg(REG_TOPB, 32'd2);
                3: write_reg(REG_TOPB, 32'd31);
                4: write_reg(REG_TOPB, 32'($urandom_range(1, 16)));
                default: write_reg(REG_TOPB, 32'd3);
            endcase
            case (ph)
                3: write_reg(REG_BASE, 32'h0);
                5: write_reg(REG_BASE, 32'hFFFF_FFFF);
                default: write_reg(REG_BASE, $urandom() & 32'hFFFF_F000);
            endcase
            calm = (ph == 2);
            // The result side holds off long enough for the input side to back up.
            if (ph == 4)
                hold_cycles = 400;
            for (int i = 0; i < 150; i++)
                random_item();
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
